FILE: rtl/core/c8cfp_pkg.sv
// package: frame constants, parser phase type, result struct and crc-8 step
`default_nettype none

package c8cfp_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hA5;
    localparam logic [7:0] HDR_SECOND = 8'h5A;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    typedef enum logic [2:0] {
        PH_HEAD0 = 3'd0,
        PH_HEAD1 = 3'd1,
        PH_TASK  = 3'd2,
        PH_SEQ   = 3'd3,
        PH_CHECK = 3'd4
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [7:0] task_id;
        logic [7:0] sequence_num;
    } t_result;

    // one byte through crc-8, msb first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // crc over the two fixed header bytes
    localparam logic [7:0] CRC_HDR = crc8_feed(crc8_feed(8'h00, HDR_FIRST), HDR_SECOND);

endpackage

`default_nettype wire

FILE: rtl/core/c8cfp_ifs.sv
// valid/ready channel interfaces for received bytes and parsed results
`default_nettype none

interface c8cfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface c8cfp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] task_id;
    logic [7:0] sequence_num;

    modport source (output valid, output task_id, output sequence_num, input ready);
    modport sink   (input valid, input task_id, input sequence_num, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/c8cfp_parser.sv
// frame phase tracker with running crc-8 over the frame bytes
`default_nettype none

module c8cfp_parser
    import c8cfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_byte,
    output t_result         o_res
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_task, n_task;
    logic [7:0] r_seq, n_seq;
    logic [7:0] r_crc, n_crc;
    logic [7:0] crc_base;

    assign crc_base = (r_phase == PH_TASK) ? CRC_HDR : r_crc;

    always_comb begin
        n_phase = r_phase;
        n_task  = r_task;
        n_seq   = r_seq;
        n_crc   = r_crc;
        if (i_en) begin
            case (r_phase)
                PH_HEAD0: begin
                    if (i_byte == HDR_FIRST) begin
                        n_phase = PH_HEAD1;
                    end
                end
                PH_HEAD1: begin
                    n_phase = (i_byte == HDR_SECOND) ? PH_TASK : PH_HEAD0;
                end
                PH_TASK: begin
                    n_task  = i_byte;
                    n_crc   = crc8_feed(crc_base, i_byte);
                    n_phase = PH_SEQ;
                end
                PH_SEQ: begin
                    n_seq   = i_byte;
                    n_crc   = crc8_feed(crc_base, i_byte);
                    n_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    n_phase = PH_HEAD0;
                end
                default: begin
                    n_phase = PH_HEAD0;
                end
            endcase
        end
    end

    always_comb begin
        o_res.valid        = i_en && (r_phase == PH_CHECK) && (i_byte == r_crc);
        o_res.task_id      = r_task;
        o_res.sequence_num = r_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD0;
            r_task  <= 8'h00;
            r_seq   <= 8'h00;
            r_crc   <= 8'h00;
        end else begin
            r_phase <= n_phase;
            r_task  <= n_task;
            r_seq   <= n_seq;
            r_crc   <= n_crc;
        end
    end

    a_check_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_CHECK) |=> (r_phase == PH_HEAD0))
        else $error("parser did not return to header hunt after check byte");

    a_result_only_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (i_en && r_phase == PH_CHECK))
        else $error("result outside check phase");

    a_bad_header_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_HEAD1 && i_byte != HDR_SECOND) |=> (r_phase == PH_HEAD0))
        else $error("wrong second header not dropped");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_phase) && $stable(r_crc))
        else $error("parser state moved without a word");

endmodule

`default_nettype wire

FILE: rtl/core/crc8_command_frame_parser_unit.sv
// top level: input register, frame parser and result register
//
//  channel  dir  payload                       width
//  i_rx     in   rx_byte                       8
//  o_res    out  task_id, sequence_num         8 + 8
//
// one word per cycle when not stalled; input register, then parser, then result register
// crc builds up in the parser one byte per cycle unless stalled; the check is one compare
// reset: synchronous active low, parser returns to hunting for the first header byte
// a pending result that is not taken stalls the input register and then i_rx.ready
`default_nettype none

module crc8_command_frame_parser_unit
    import c8cfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    c8cfp_rx_if.sink     i_rx,
    c8cfp_res_if.source  o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_task_id;
    logic [7:0] r_sequence_num;
    logic       advance;
    t_result    res;

    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    c8cfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_task_id      <= res.task_id;
            r_sequence_num <= res.sequence_num;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.task_id      = r_task_id;
    assign o_res.sequence_num = r_sequence_num;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench for the crc-8 command frame parser: directed frames, random streams, self-checking
`timescale 1ns / 100ps

module testbench;
    import c8cfp_pkg::*;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_CRC_GOOD,
        ROW_CRC_BAD
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] data;
        logic       typed;
        logic [7:0] exp_task;
        logic [7:0] exp_seq;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] task_id;
        logic [7:0] sequence_num;
    } frame_result_t;

    localparam int NUM_ROWS    = 24;
    localparam int TOTAL_BYTES = 1650;

    // crc rows: data is the xor mask applied to the good check byte
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_BYTE,     HDR_FIRST,  1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_SECOND, 1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     8'h00,      1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     8'h00,      1'b0, 8'h00, 8'h00},
        '{ROW_CRC_GOOD, 8'h00,      1'b1, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_FIRST,  1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_SECOND, 1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     8'hFF,      1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     8'hFF,      1'b0, 8'h00, 8'h00},
        '{ROW_CRC_GOOD, 8'h00,      1'b1, 8'hFF, 8'hFF},
        // repeated first header byte is not taken as a fresh start
        '{ROW_BYTE,     HDR_FIRST,  1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_FIRST,  1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_SECOND, 1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     8'hC3,      1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_FIRST,  1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_SECOND, 1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     8'h3C,      1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     8'hC3,      1'b0, 8'h00, 8'h00},
        '{ROW_CRC_BAD,  8'h80,      1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_FIRST,  1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_SECOND, 1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_FIRST,  1'b0, 8'h00, 8'h00},
        '{ROW_BYTE,     HDR_SECOND, 1'b0, 8'h00, 8'h00},
        '{ROW_CRC_GOOD, 8'h00,      1'b1, HDR_FIRST, HDR_SECOND}
    };

    logic i_clk;
    logic i_rst_n;

    c8cfp_rx_if  rx_ch ();
    c8cfp_res_if res_ch ();

    crc8_command_frame_parser_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    t_phase          parse_state   = PH_HEAD0;
    logic [7:0]      held_task_q   = 8'h00;
    logic [7:0]      held_seq_q    = 8'h00;
    frame_result_t   pending_frames [$];
    int              error_count   = 0;
    int              bytes_sent    = 0;
    int              frames_seen   = 0;
    int              frames_dropped = 0;
    int              src_idle_pct  = 23;
    int              sink_idle_pct = 58;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // msb-first crc-8, one data bit per iteration
    function automatic logic [7:0] crc8_bitwise(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[7] ^ data[k];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] frame_check(input logic [7:0] tid, input logic [7:0] seq);
        return crc8_bitwise(crc8_bitwise(crc8_bitwise(crc8_bitwise(8'h00, HDR_FIRST),
                                                      HDR_SECOND), tid), seq);
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b, output bit hit, output frame_result_t res);
        hit = 1'b0;
        res = '0;
        case (parse_state)
            PH_HEAD0: begin
                if (b == HDR_FIRST) parse_state = PH_HEAD1;
            end
            PH_HEAD1: begin
                parse_state = (b == HDR_SECOND) ? PH_TASK : PH_HEAD0;
            end
            PH_TASK: begin
                held_task_q = b;
                parse_state = PH_SEQ;
            end
            PH_SEQ: begin
                held_seq_q  = b;
                parse_state = PH_CHECK;
            end
            PH_CHECK: begin
                if (b == frame_check(held_task_q, held_seq_q)) begin
                    hit = 1'b1;
                    res = '{held_task_q, held_seq_q};
                end else begin
                    frames_dropped++;
                end
                parse_state = PH_HEAD0;
            end
            default: begin
                parse_state = PH_HEAD0;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t typed_res);
        bit            hit;
        frame_result_t res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        bytes_sent++;
        parse_rx_byte(b, hit, res);
        if (typed) begin
            if (!hit || res != typed_res) begin
                $display("%0t: table row expects %02h/%02h, parser model gives %0d %02h/%02h",
                         $time, typed_res.task_id, typed_res.sequence_num, hit,
                         res.task_id, res.sequence_num);
                error_count++;
            end
            pending_frames.push_back(typed_res);
        end else if (hit) begin
            pending_frames.push_back(res);
        end
    endtask

    task automatic send_random_burst();
        logic [7:0] tid;
        logic [7:0] seq;
        logic [7:0] junk;
        int         pick;
        tid  = 8'($urandom);
        seq  = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            send_byte(HDR_FIRST, 1'b0, '0);
            send_byte(HDR_SECOND, 1'b0, '0);
            send_byte(tid, 1'b0, '0);
            send_byte(seq, 1'b0, '0);
            if (pick < 70) begin
                send_byte(frame_check(tid, seq), 1'b0, '0);
            end else begin
                send_byte(frame_check(tid, seq) ^ 8'($urandom_range(1, 255)), 1'b0, '0);
            end
        end else if (pick < 86) begin
            // broken header
            junk = 8'($urandom);
            if (junk == HDR_SECOND) junk = HDR_FIRST;
            send_byte(HDR_FIRST, 1'b0, '0);
            send_byte(junk, 1'b0, '0);
        end else if (pick < 92) begin
            // truncated frame, next frame bytes get swallowed
            send_byte(HDR_FIRST, 1'b0, '0);
            send_byte(HDR_SECOND, 1'b0, '0);
            send_byte(tid, 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0);
        end
    endtask

    task automatic wait_results_done();
        int guard;
        guard = 0;
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending_frames.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        res_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected word, expected none got %02h/%02h",
                         $time, res_ch.task_id, res_ch.sequence_num);
                error_count++;
            end else begin
                frames_seen++;
                if (res_ch.task_id !== pending_frames[0].task_id ||
                    res_ch.sequence_num !== pending_frames[0].sequence_num) begin
                    $display("%0t: mismatch task_id/sequence_num expected %02h/%02h got %02h/%02h",
                             $time, pending_frames[0].task_id, pending_frames[0].sequence_num,
                             res_ch.task_id, res_ch.sequence_num);
                    error_count++;
                end
                void'(pending_frames.pop_front());
            end
        end
    end

    initial begin
        stim_row_t  row;
        logic [7:0] b;
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NUM_ROWS; n++) begin
            row = DIRECTED_ROWS[n];
            case (row.kind)
                ROW_CRC_GOOD: b = frame_check(held_task_q, held_seq_q);
                ROW_CRC_BAD:  b = frame_check(held_task_q, held_seq_q) ^ row.data;
                default:      b = row.data;
            endcase
            send_byte(b, row.typed, '{row.exp_task, row.exp_seq});
        end

        while (bytes_sent < TOTAL_BYTES / 3) send_random_burst();
        // sender holds off until every expected frame has come out or the wait guard runs out
        wait_results_done();

        src_idle_pct  = 58;
        sink_idle_pct = 23;
        while (bytes_sent < 2 * TOTAL_BYTES / 3) send_random_burst();
        wait_results_done();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (bytes_sent < TOTAL_BYTES) send_random_burst();
        wait_results_done();

        if (pending_frames.size() != 0) begin
            $display("%0t: %0d frames expected but never came out", $time, pending_frames.size());
            error_count++;
        end

        $display("run: %0d bytes in, %0d frames out, %0d frames failed crc",
                 bytes_sent, frames_seen, frames_dropped);
        $display("stall patterns: sender-heavy, receiver-heavy, none; %0d errors", error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/c8cfp_pkg.sv
rtl/core/c8cfp_ifs.sv
rtl/core/c8cfp_parser.sv
rtl/core/crc8_command_frame_parser_unit.sv
bench/testbench.sv
